### design/assert_macros.svh
// Assertion macros shared by the frame validator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/crcfv_pkg.sv
// Types, constants and the CRC-16 byte update for the frame validator.
// Depends on nothing; imported by every module of the block.
package crcfv_pkg;

  // Frame layout and sizing.
  localparam int HDR_LEN              = 16;
  localparam int FLEN_W               = 17;
  localparam int MAX_REPORT_BYTES_DEF = 64;
  localparam int OUT_LEN_W            = 7;

  // CRC-16/CCITT-FALSE constants.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // Configuration port.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_VERSION  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDING_ALLOWED = 8'd3;

  // Byte offsets within the 16-byte header.
  typedef enum logic [3:0] {
    OFF_MAGIC0, OFF_MAGIC1, OFF_VERSION, OFF_RSVD,
    OFF_ID0, OFF_ID1, OFF_ID2, OFF_ID3,
    OFF_NUM_LO, OFF_NUM_HI, OFF_TOT_LO, OFF_TOT_HI,
    OFF_LEN_LO, OFF_LEN_HI, OFF_CRC_LO, OFF_CRC_HI
  } hdr_off_t;

  typedef struct packed {
    logic [7:0] report_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic                 frame_ok;
    logic [OUT_LEN_W-1:0] frame_bytes;
  } out_word_t;

  typedef struct packed {
    logic [7:0] magic_first;
    logic [7:0] magic_second;
    logic [7:0] format_version;
    logic       padding_allowed;
  } cfg_t;

  // One byte of CRC update, MSB first, unrolled into XOR logic.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### design/crcfv_cfg_regs.sv
// Configuration register file of the frame validator.
// Depends on crcfv_pkg for the register indexes and cfg_t.
module crcfv_cfg_regs
  import crcfv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are always accepted.
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode the register index; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAGIC_FIRST:     cfg_nxt.magic_first     = cfg_wdata;
        CFG_MAGIC_SECOND:    cfg_nxt.magic_second    = cfg_wdata;
        CFG_FORMAT_VERSION:  cfg_nxt.format_version  = cfg_wdata;
        CFG_PADDING_ALLOWED: cfg_nxt.padding_allowed = cfg_wdata[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### design/crcfv_in_stage.sv
// Input register of the frame validator: holds one accepted word.
// Depends on crcfv_pkg for in_word_t.
module crcfv_in_stage
  import crcfv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     vld,
  output in_word_t word,
  input  logic     take
);

  logic     vld_r;
  in_word_t word_r;

  // A new word enters when the register is empty or is being consumed.
  assign in_ready = !vld_r || take;
  assign vld      = vld_r;
  assign word     = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (take) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_data;
    end
  end

  `include "assert_macros.svh"

  // The check stage only consumes a word that is actually held.
  `AST_IMPL(a_take_needs_word, clk, rst_n, take, vld_r)

endmodule

### design/crcfv_check.sv
// Header decode, CRC update, frame verdict: a byte per cycle unless stalled.
// Depends on crcfv_pkg for types, header offsets and crc16_byte.
module crcfv_check
  import crcfv_pkg::*;
#(
  parameter int MAX_REPORT_BYTES = MAX_REPORT_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      vld,
  input  in_word_t  word,
  input  logic      out_can_take,
  output logic      take,
  output logic      res_load,
  output out_word_t res_word
);

  localparam int PW = $clog2(MAX_REPORT_BYTES + 2);
  localparam logic [PW-1:0] POS_SAT = PW'(MAX_REPORT_BYTES + 1);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_REPORT_BYTES);
  localparam logic [PW-1:0] POS_HDR = PW'(HDR_LEN);

  logic [PW-1:0] pos_r, pos_nxt;
  logic          hdr_good_r, hdr_good_nxt;
  logic          id_nz_r, id_nz_nxt;
  logic [15:0]   chunk_num_r, chunk_num_nxt;
  logic [15:0]   chunk_tot_r, chunk_tot_nxt;
  logic [15:0]   pay_size_r, pay_size_nxt;
  logic [15:0]   crc_exp_r, crc_exp_nxt;
  logic [15:0]   crc_run_r, crc_run_nxt;
  logic          tail_zero_r, tail_zero_nxt;

  logic [7:0]        b;
  logic [FLEN_W-1:0] frame_len;
  logic [FLEN_W-1:0] len_ext;
  logic              ok;

  assign b = word.report_byte;

  // A word that ends a report waits until the result register can take it.
  assign take     = vld && (!word.is_last || out_can_take);
  assign res_load = take && word.is_last;

  // State update for the byte in the input register.
  always_comb begin
    pos_nxt       = pos_r;
    hdr_good_nxt  = hdr_good_r;
    id_nz_nxt     = id_nz_r;
    chunk_num_nxt = chunk_num_r;
    chunk_tot_nxt = chunk_tot_r;
    pay_size_nxt  = pay_size_r;
    crc_exp_nxt   = crc_exp_r;
    crc_run_nxt   = crc_run_r;
    tail_zero_nxt = tail_zero_r;

    if (pos_r < POS_HDR) begin
      unique case (hdr_off_t'(pos_r[3:0]))
        OFF_MAGIC0:  if (b != cfg.magic_first)    hdr_good_nxt = 1'b0;
        OFF_MAGIC1:  if (b != cfg.magic_second)   hdr_good_nxt = 1'b0;
        OFF_VERSION: if (b != cfg.format_version) hdr_good_nxt = 1'b0;
        OFF_RSVD:    if (b != 8'h00)              hdr_good_nxt = 1'b0;
        OFF_ID0, OFF_ID1, OFF_ID2, OFF_ID3: begin
          if (b != 8'h00) id_nz_nxt = 1'b1;
        end
        OFF_NUM_LO:  chunk_num_nxt = {chunk_num_r[15:8], b};
        OFF_NUM_HI:  chunk_num_nxt = {b, chunk_num_r[7:0]};
        OFF_TOT_LO:  chunk_tot_nxt = {chunk_tot_r[15:8], b};
        OFF_TOT_HI:  chunk_tot_nxt = {b, chunk_tot_r[7:0]};
        OFF_LEN_LO:  pay_size_nxt  = {pay_size_r[15:8], b};
        OFF_LEN_HI:  pay_size_nxt  = {b, pay_size_r[7:0]};
        OFF_CRC_LO:  crc_exp_nxt   = {crc_exp_r[15:8], b};
        OFF_CRC_HI:  crc_exp_nxt   = {b, crc_exp_r[7:0]};
        default:     hdr_good_nxt  = hdr_good_r;
      endcase
    end else if (FLEN_W'(pos_r) < (FLEN_W'(HDR_LEN) + FLEN_W'(pay_size_r))) begin
      crc_run_nxt = crc16_byte(crc_run_r, b);
    end else if (b != 8'h00) begin
      tail_zero_nxt = 1'b0;
    end

    // The byte counter saturates one past the longest legal report.
    if (pos_r < POS_SAT) begin
      pos_nxt = pos_r + PW'(1);
    end
  end

  // Verdict for a report that ends with this byte.
  assign frame_len = FLEN_W'(HDR_LEN) + FLEN_W'(pay_size_nxt);
  assign len_ext   = FLEN_W'(pos_nxt);

  always_comb begin
    ok = (pos_nxt >= POS_HDR) && (pos_nxt <= POS_MAX) &&
         hdr_good_nxt && id_nz_nxt && (chunk_tot_nxt != 16'h0000) &&
         (chunk_num_nxt < chunk_tot_nxt) && (frame_len <= len_ext) &&
         (cfg.padding_allowed || (frame_len == len_ext)) &&
         (crc_run_nxt == crc_exp_nxt) && tail_zero_nxt;
    res_word.frame_ok    = ok;
    res_word.frame_bytes = ok ? frame_len[OUT_LEN_W-1:0] : '0;
  end

  // Per-report state; cleared after the last byte of each report.
  always_ff @(posedge clk) begin
    if (!rst_n || (take && word.is_last)) begin
      pos_r       <= '0;
      hdr_good_r  <= 1'b1;
      id_nz_r     <= 1'b0;
      chunk_num_r <= '0;
      chunk_tot_r <= '0;
      pay_size_r  <= '0;
      crc_exp_r   <= '0;
      crc_run_r   <= CRC_INIT;
      tail_zero_r <= 1'b1;
    end else if (take) begin
      pos_r       <= pos_nxt;
      hdr_good_r  <= hdr_good_nxt;
      id_nz_r     <= id_nz_nxt;
      chunk_num_r <= chunk_num_nxt;
      chunk_tot_r <= chunk_tot_nxt;
      pay_size_r  <= pay_size_nxt;
      crc_exp_r   <= crc_exp_nxt;
      crc_run_r   <= crc_run_nxt;
      tail_zero_r <= tail_zero_nxt;
    end
  end

  `include "assert_macros.svh"

  // The byte counter never runs past its saturation point.
  `AST_IMPL(a_pos_bound, clk, rst_n, 1'b1, pos_r <= POS_SAT)
  // The end of a report restarts the count and the CRC.
  `AST_NEXT(a_report_restart, clk, rst_n, res_load, (pos_r == '0) && (crc_run_r == CRC_INIT))
  // A passing verdict always reports at least a full header.
  `AST_IMPL(a_ok_len, clk, rst_n, res_load && res_word.frame_ok, frame_len >= FLEN_W'(HDR_LEN))

endmodule

### design/crcfv_out_stage.sv
// Result register of the frame validator.
// Depends on crcfv_pkg for out_word_t.
module crcfv_out_stage
  import crcfv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_load,
  input  out_word_t res_word,
  output logic      out_can_take,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic      valid_r;
  out_word_t data_r;

  // Room for a new result when empty or when the held one leaves now.
  assign out_can_take = !valid_r || out_ready;
  assign out_valid    = valid_r;
  assign out_data     = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      data_r <= res_word;
    end
  end

  `include "assert_macros.svh"

  // A result is never loaded over one that is still waiting.
  `AST_IMPL(a_no_overwrite, clk, rst_n, res_load, !valid_r || out_ready)

endmodule

### design/crc_checked_frame_validator_core.sv
// Top level of the CRC-checked frame validator.
// Depends on crcfv_pkg and the cfg_regs, in_stage, check and out_stage modules.
//
//   Channel  Direction  Handshake              Word
//   in       input      in_valid / in_ready    in_data: report_byte, is_last
//   out      output     out_valid / out_ready  out_data: frame_ok, frame_bytes
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// Throughput is one report byte per cycle unless an output stall holds a last byte;
// the last byte of a report passes the input register, its result the result register.
// The per-byte path is one unrolled 8-bit CRC update plus the verdict compares.
// Reset is synchronous and active low; no clearing pass is needed.
// A stall on the output holds only words that end a report; other bytes drain.
module crc_checked_frame_validator_core
  import crcfv_pkg::*;
#(
  parameter int MAX_REPORT_BYTES = MAX_REPORT_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  logic      vld;
  in_word_t  word;
  logic      take;
  logic      out_can_take;
  logic      res_load;
  out_word_t res_word;

  crcfv_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  crcfv_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .vld      (vld),
    .word     (word),
    .take     (take)
  );

  crcfv_check #(
    .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
  ) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .vld          (vld),
    .word         (word),
    .out_can_take (out_can_take),
    .take         (take),
    .res_load     (res_load),
    .res_word     (res_word)
  );

  crcfv_out_stage u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_load     (res_load),
    .res_word     (res_word),
    .out_can_take (out_can_take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule
